/* rtl/stable_priority_queue_defines.svh */
// ----------------------------------------------------------------------------
// Stable priority queue assertion macros
// Concurrent assertion wrappers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTH
// Checked property, disabled while reset is asserted.
`define SPQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("spq assertion failed");
// Checked property that also holds during reset.
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("spq assertion failed");
`else
`define SPQ_ASSERT(lbl, clk, rst_n, prop)
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// Stable priority queue package
// Request and result types, operation and status codes, controller states.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int OCC_W = 5;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_POPPED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_EMPTY  = 2'd2,
        OP_FULL   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } t_state;

    // Request kinds.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_POP    = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [15:0] task_id;
        logic [15:0] run_time;
        logic [7:0]  prio;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic [15:0]      out_id;
        logic [15:0]      out_time;
        logic [7:0]       out_prio;
        logic [OCC_W-1:0] occupancy;
    } t_out;

    typedef struct packed {
        logic [15:0] task_id;
        logic [15:0] run_time;
        logic [7:0]  prio;
    } t_entry;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic exec;
        t_op  op;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic kind;
        logic empty;
        logic full;
    } t_dp_sts;

endpackage

/* rtl/spq_ctrl.sv */
// ----------------------------------------------------------------------------
// Stable priority queue controller
// Sequences request capture, execution and result hand-off.
// ----------------------------------------------------------------------------
module spq_ctrl
    import spq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   in_accept;
    logic   out_accept;

    assign in_accept  = i_in_valid && o_in_ready;
    assign out_accept = o_out_valid && i_out_ready;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_accept) n_state = in_accept ? S_EXEC : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands.
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd.exec  = 1'b0;
        o_cmd.op    = OP_INSERT;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.kind == KIND_INSERT) begin
                    o_cmd.op = i_sts.full ? OP_FULL : OP_INSERT;
                end else begin
                    o_cmd.op = i_sts.empty ? OP_EMPTY : OP_POP;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                o_in_ready  = i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
        o_cmd.load = i_in_valid && o_in_ready;
    end

endmodule

/* rtl/spq_dp.sv */
// ----------------------------------------------------------------------------
// Stable priority queue datapath
// Sorted shift line of entries; every cell compares against the new request
// in parallel, so an insert or a pop updates the whole line together.
// ----------------------------------------------------------------------------
`include "stable_priority_queue_defines.svh"

module spq_dp
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_in     i_req,
    input  t_dp_cmd i_cmd,
    output t_dp_sts o_sts,
    output t_out    o_res
);

    localparam int CW = $clog2(CAPACITY + 1);

    t_in              r_req;
    t_out             r_res, n_res;
    logic [CW-1:0]    r_count, n_count;
    t_entry           r_slots [CAPACITY];
    t_entry           n_slots [CAPACITY];
    t_entry           cell_ins [CAPACITY];
    t_entry           cell_pop [CAPACITY];
    logic [CAPACITY-1:0] at_or_after;
    t_entry           new_e;
    logic [CW+OCC_W-1:0] occ_ext;
    logic             exec_pop;
    logic             exec_reject;
    logic             head_in_order;

    assign new_e.task_id  = r_req.task_id;
    assign new_e.run_time = r_req.run_time;
    assign new_e.prio     = r_req.prio;

    // Status for the controller.
    assign o_sts.kind  = r_req.kind;
    assign o_sts.empty = (r_count == '0);
    assign o_sts.full  = (r_count == CW'(CAPACITY));
    assign o_res       = r_res;

    // Per-cell insert and pop candidates.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        // Cell lies at or behind the insert point: empty or holds a larger number.
        assign at_or_after[g] = (CW'(g) >= r_count) || (r_slots[g].prio > new_e.prio);
        if (g == 0) begin : g_head
            assign cell_ins[g] = at_or_after[g] ? new_e : r_slots[g];
        end else begin : g_body
            assign cell_ins[g] = !at_or_after[g]     ? r_slots[g] :
                                 !at_or_after[g - 1] ? new_e      : r_slots[g - 1];
        end
        if (g < CAPACITY - 1) begin : g_shift
            assign cell_pop[g] = r_slots[g + 1];
        end else begin : g_tail
            assign cell_pop[g] = r_slots[g];
        end
    end

    // Next slot contents.
    always_comb begin
        n_slots = r_slots;
        if (i_cmd.exec) begin
            case (i_cmd.op)
                OP_INSERT: n_slots = cell_ins;
                OP_POP:    n_slots = cell_pop;
                default:   n_slots = r_slots;
            endcase
        end
    end

    // Next count.
    always_comb begin
        n_count = r_count;
        if (i_cmd.exec) begin
            case (i_cmd.op)
                OP_INSERT: n_count = r_count + 1'b1;
                OP_POP:    n_count = r_count - 1'b1;
                default:   n_count = r_count;
            endcase
        end
    end

    assign occ_ext = {{OCC_W{1'b0}}, n_count};

    // Next result.
    always_comb begin
        n_res = r_res;
        if (i_cmd.exec) begin
            n_res.out_id    = '0;
            n_res.out_time  = '0;
            n_res.out_prio  = '0;
            n_res.occupancy = occ_ext[OCC_W-1:0];
            case (i_cmd.op)
                OP_INSERT: n_res.status = ST_INSERTED;
                OP_POP: begin
                    n_res.status   = ST_POPPED;
                    n_res.out_id   = r_slots[0].task_id;
                    n_res.out_time = r_slots[0].run_time;
                    n_res.out_prio = r_slots[0].prio;
                end
                OP_EMPTY:  n_res.status = ST_EMPTY;
                default:   n_res.status = ST_FULL;
            endcase
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_req <= i_req;
        r_res   <= n_res;
        r_slots <= n_slots;
    end

    // Terms used by the checks below.
    assign exec_pop      = i_cmd.exec && (i_cmd.op == OP_POP);
    assign exec_reject   = i_cmd.exec && (i_cmd.op == OP_FULL || i_cmd.op == OP_EMPTY);
    assign head_in_order = (r_slots[0].prio <= r_slots[1].prio);

    // The count never passes the capacity.
    `SPQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(CAPACITY))
    // A pop removes exactly one entry.
    `SPQ_ASSERT(a_pop_dec, i_clk, i_rst_n, exec_pop |=> (r_count == CW'($past(r_count) - 1'b1)))
    // A dropped insert or an empty pop leaves the count alone.
    `SPQ_ASSERT(a_reject_hold, i_clk, i_rst_n, exec_reject |=> $stable(r_count))
    // The head never has a larger number than the entry behind it.
    `SPQ_ASSERT(a_head_sorted, i_clk, i_rst_n, (r_count >= CW'(2)) |-> head_in_order)

endmodule

/* rtl/stable_priority_queue.sv */
// ----------------------------------------------------------------------------
// Stable priority queue
// Flow: an accepted request is captured, then executed in the execute state;
// its result is then held valid in the output state until it is taken.
// Issue: no new request is taken until the previous result leaves; a new
// request can be taken in the same cycle as the previous result leaves.
// Reset: synchronous, active low; the queue comes out of reset empty.
// ----------------------------------------------------------------------------
module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer.
    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Sorted entry store.
    spq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_in_data),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_res   (o_out_data)
    );

endmodule
